[hdl/bir_pkg.sv]
// ---------------------------------------------------------------------------
// bir_pkg
// Shared types, widths and helpers for the bilinear image resampler.
// ---------------------------------------------------------------------------
package bir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_W      = 256;
    localparam int MAX_H      = 256;
    localparam int IDX_W      = 8;
    localparam int SIZE_W     = 9;
    localparam int LOAD_W     = 12;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int BANK_DEPTH = (MAX_W / 2) * (MAX_H / 2);
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int PROD_W     = 45;
    localparam int COORD_W    = 46;
    localparam int FRAC_W     = 47;
    localparam int FRAC_LO    = 23;
    localparam int PA_W       = 41;
    localparam int BLEND_W    = 49;
    localparam int DIFF_W     = 50;
    localparam int E_LO       = 24;
    localparam int WIDE_W     = 98;

    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd5;

    typedef struct packed {
        logic signed [CFG_W-1:0] x_origin;
        logic signed [CFG_W-1:0] x_step;
        logic signed [CFG_W-1:0] y_origin;
        logic signed [CFG_W-1:0] y_step;
        logic [SIZE_W-1:0]       src_width;
        logic [SIZE_W-1:0]       src_height;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]        i0;
        logic [IDX_W-1:0]        i1;
        logic signed [FRAC_W-1:0] frac;
    } axis_t;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic                     query;
        logic                     load_ok;
        logic [IDX_W-1:0]         x0;
        logic [IDX_W-1:0]         x1;
        logic [IDX_W-1:0]         y0;
        logic [IDX_W-1:0]         y1;
        logic signed [FRAC_W-1:0] u;
        logic signed [FRAC_W-1:0] v;
        logic [SAMPLE_W-1:0]      sample;
    } job_t;

    // A size of zero acts as one; anything above the store bound acts as the bound.
    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s,
                                                   logic [SIZE_W-1:0] bound);
        logic [SIZE_W-1:0] r;
        if (s == '0)
            r = SIZE_W'(1);
        else if (s > bound)
            r = bound;
        else
            r = s;
        return r;
    endfunction

    // Base index truncated toward zero and clamped, neighbour and fraction.
    function automatic axis_t resolve_axis(logic signed [COORD_W-1:0] c,
                                           logic [SIZE_W-1:0] size);
        logic [COORD_W-17:0] whole;
        logic [SIZE_W-1:0]   top_idx;
        logic [SIZE_W-1:0]   base;
        logic [SIZE_W-1:0]   nb;
        axis_t               r;
        top_idx = size - SIZE_W'(1);
        whole   = c[COORD_W-1:16];
        if (c[COORD_W-1])
            base = '0;
        else if (whole > {{(COORD_W-16-SIZE_W){1'b0}}, top_idx})
            base = top_idx;
        else
            base = whole[SIZE_W-1:0];
        nb = ((base + SIZE_W'(1)) < size) ? base + SIZE_W'(1) : top_idx;
        r.i0   = base[IDX_W-1:0];
        r.i1   = nb[IDX_W-1:0];
        r.frac = FRAC_W'(c) - $signed(FRAC_W'({base, 16'h0000}));
        return r;
    endfunction

endpackage

[hdl/bir_ram.sv]
// ---------------------------------------------------------------------------
// bir_ram
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module bir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/bir_front.sv]
// ---------------------------------------------------------------------------
// bir_front
// Accepts items, maps query coordinates into the source image and
// classifies each item as a load or a query for the back end.
// ---------------------------------------------------------------------------
module bir_front import bir_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                cmd,
    input  logic [LOAD_W-1:0]   col,
    input  logic [LOAD_W-1:0]   row,
    input  logic [SAMPLE_W-1:0] sample,
    input  cfg_t                cfg,
    output logic                push,
    output job_t                job
);

    logic                      valid_reg;
    logic                      cmd_reg;
    logic [LOAD_W-1:0]         col_reg;
    logic [LOAD_W-1:0]         row_reg;
    logic [SAMPLE_W-1:0]       sample_reg;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;

    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    axis_t                     ax;
    axis_t                     ay;
    logic [SIZE_W-1:0]         w_eff;
    logic [SIZE_W-1:0]         h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            col_reg    <= col;
            row_reg    <= row;
            sample_reg <= sample;
            px_reg     <= $signed({1'b0, col}) * cfg.x_step;
            py_reg     <= $signed({1'b0, row}) * cfg.y_step;
        end
    end

    always_comb
    begin
        w_eff = eff_size(cfg.src_width, SIZE_W'(MAX_W));
        h_eff = eff_size(cfg.src_height, SIZE_W'(MAX_H));
        cx    = COORD_W'(cfg.x_origin) + COORD_W'(px_reg);
        cy    = COORD_W'(cfg.y_origin) + COORD_W'(py_reg);
        ax    = resolve_axis(cx, w_eff);
        ay    = resolve_axis(cy, h_eff);

        job.query   = cmd_reg;
        job.load_ok = !cmd_reg && (col_reg[LOAD_W-1:IDX_W] == '0)
                      && (row_reg[LOAD_W-1:IDX_W] == '0);
        job.sample  = sample_reg;
        job.u       = ax.frac;
        job.v       = ay.frac;
        if (cmd_reg)
        begin
            job.x0 = ax.i0;
            job.x1 = ax.i1;
            job.y0 = ay.i0;
            job.y1 = ay.i1;
        end
        else
        begin
            job.x0 = col_reg[IDX_W-1:0];
            job.x1 = col_reg[IDX_W-1:0];
            job.y0 = row_reg[IDX_W-1:0];
            job.y1 = row_reg[IDX_W-1:0];
        end
    end

    assign push = valid_reg;

endmodule

[hdl/bir_queue.sv]
// ---------------------------------------------------------------------------
// bir_queue
// Short first-in first-out queue of classified items between the two ends.
// ---------------------------------------------------------------------------
module bir_queue import bir_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t job_in,
    input  logic pop,
    output job_t job_out,
    output logic empty,
    output logic nearly_full
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    job_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + (PTR_W + 1)'(1);
        else if (!push && do_pop)
            count_next = count_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign job_out     = slot_reg[rd_ptr_reg];
    assign empty       = (count_reg == '0);
    // One item may still be in the front end when it is told to stop.
    assign nearly_full = (count_reg >= (PTR_W + 1)'(DEPTH - 2));

endmodule

[hdl/bir_back.sv]
// ---------------------------------------------------------------------------
// bir_back
// Carries out items: writes loads into the four parity banks, reads the
// four neighbours of a query and blends them through a multiplier pipeline.
// ---------------------------------------------------------------------------
module bir_back import bir_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  job_t                job,
    output logic                pop,
    output logic                done,
    output logic [SAMPLE_W-1:0] value,
    output logic                saturated
);

    logic [SAMPLE_W-1:0] rd [4];

    // Stage 0: bank access
    logic                     b0_valid_reg;
    logic [3:0]               b0_par_reg;
    logic signed [FRAC_W-1:0] b0_u_reg;
    logic signed [FRAC_W-1:0] b0_v_reg;

    // Stage 1: differences and first products
    logic                     b1_valid_reg;
    logic signed [SAMPLE_W-1:0] b1_f00_reg;
    logic signed [SAMPLE_W-1:0] b1_f01_reg;
    logic signed [PA_W-1:0]   b1_pah_a_reg;
    logic signed [PA_W-1:0]   b1_pal_a_reg;
    logic signed [PA_W-1:0]   b1_pah_b_reg;
    logic signed [PA_W-1:0]   b1_pal_b_reg;
    logic signed [FRAC_W-1:0] b1_v_reg;

    // Stage 2: horizontal blends
    logic                     b2_valid_reg;
    logic signed [BLEND_W-1:0] b2_a_reg;
    logic signed [BLEND_W-1:0] b2_b_reg;
    logic signed [FRAC_W-1:0] b2_v_reg;

    // Stage 3: vertical partial products
    logic                     b3_valid_reg;
    logic signed [BLEND_W-1:0] b3_a_reg;
    logic signed [49:0]       b3_hh_reg;
    logic signed [48:0]       b3_hl_reg;
    logic signed [49:0]       b3_lh_reg;
    logic signed [48:0]       b3_ll_reg;

    // Stage 4: summed and limited product
    logic                     b4_valid_reg;
    logic signed [BLEND_W-1:0] b4_a_reg;
    logic signed [63:0]       b4_ps_reg;

    // Output
    logic                     done_reg;
    logic [SAMPLE_W-1:0]      value_reg;
    logic                     sat_reg;

    assign pop = !empty;

    genvar k;
    generate
        for (k = 0; k < 4; k++)
        begin : g_bank
            logic [IDX_W-1:0]   xs;
            logic [IDX_W-1:0]   ys;
            logic               we;
            logic [BANK_AW-1:0] raddr;
            logic [BANK_AW-1:0] waddr;

            // Bank k holds the samples whose row parity is k[1] and column parity k[0].
            always_comb
            begin
                xs    = (job.x0[0] == k[0]) ? job.x0 : job.x1;
                ys    = (job.y0[0] == k[1]) ? job.y0 : job.y1;
                raddr = {ys[IDX_W-1:1], xs[IDX_W-1:1]};
                waddr = {job.y0[IDX_W-1:1], job.x0[IDX_W-1:1]};
                we    = pop && job.load_ok && (job.x0[0] == k[0]) && (job.y0[0] == k[1]);
            end

            bir_ram #(
                .WIDTH (SAMPLE_W),
                .DEPTH (BANK_DEPTH)
            ) u_bank (
                .clk   (clk),
                .we    (we),
                .waddr (waddr),
                .wdata (job.sample),
                .raddr (raddr),
                .rdata (rd[k])
            );
        end
    endgenerate

    logic signed [SAMPLE_W-1:0] f00, f10, f01, f11;
    logic signed [SAMPLE_W:0]   d0, d1;
    logic signed [23:0]         uh, ul;

    always_comb
    begin
        f00 = $signed(rd[{b0_par_reg[2], b0_par_reg[0]}]);
        f10 = $signed(rd[{b0_par_reg[2], b0_par_reg[1]}]);
        f01 = $signed(rd[{b0_par_reg[3], b0_par_reg[0]}]);
        f11 = $signed(rd[{b0_par_reg[3], b0_par_reg[1]}]);
        d0  = (SAMPLE_W + 1)'(f10) - (SAMPLE_W + 1)'(f00);
        d1  = (SAMPLE_W + 1)'(f11) - (SAMPLE_W + 1)'(f01);
        uh  = $signed(b0_u_reg[FRAC_W-1:FRAC_LO]);
        ul  = $signed({1'b0, b0_u_reg[FRAC_LO-1:0]});
    end

    logic signed [63:0]         pa, pb;

    always_comb
    begin
        pa = (64'(b1_pah_a_reg) <<< FRAC_LO) + 64'(b1_pal_a_reg);
        pb = (64'(b1_pah_b_reg) <<< FRAC_LO) + 64'(b1_pal_b_reg);
    end

    logic signed [DIFF_W-1:0] e;
    logic signed [23:0]       vh, vl;
    logic signed [25:0]       eh;
    logic signed [24:0]       el;

    always_comb
    begin
        e  = DIFF_W'(b2_b_reg) - DIFF_W'(b2_a_reg);
        vh = $signed(b2_v_reg[FRAC_W-1:FRAC_LO]);
        vl = $signed({1'b0, b2_v_reg[FRAC_LO-1:0]});
        eh = $signed(e[DIFF_W-1:E_LO]);
        el = $signed({1'b0, e[E_LO-1:0]});
    end

    localparam logic signed [WIDE_W-1:0] WIDE_LIM = WIDE_W'(64'sd1 <<< 62);
    logic signed [WIDE_W-1:0] pw;
    logic signed [63:0]       ps;

    always_comb
    begin
        pw = (WIDE_W'(b3_hh_reg) <<< (FRAC_LO + E_LO))
             + (WIDE_W'(b3_hl_reg) <<< FRAC_LO)
             + (WIDE_W'(b3_lh_reg) <<< E_LO)
             + WIDE_W'(b3_ll_reg);
        if (pw > WIDE_LIM)
            ps = 64'(WIDE_LIM);
        else if (pw < -WIDE_LIM)
            ps = 64'(-WIDE_LIM);
        else
            ps = 64'(pw);
    end

    localparam logic signed [DIFF_W-1:0] OUT_HI = DIFF_W'(32767);
    localparam logic signed [DIFF_W-1:0] OUT_LO = -DIFF_W'(32768);
    logic signed [DIFF_W-1:0] r;

    always_comb
    begin
        r = DIFF_W'(b4_a_reg) + DIFF_W'((b4_ps_reg + 64'sd32768) >>> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b0_valid_reg <= pop && job.query;
            b1_valid_reg <= b0_valid_reg;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            done_reg     <= b4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_par_reg   <= {job.y1[0], job.y0[0], job.x1[0], job.x0[0]};
        b0_u_reg     <= job.u;
        b0_v_reg     <= job.v;

        b1_f00_reg   <= f00;
        b1_f01_reg   <= f01;
        b1_pah_a_reg <= uh * d0;
        b1_pal_a_reg <= ul * d0;
        b1_pah_b_reg <= uh * d1;
        b1_pal_b_reg <= ul * d1;
        b1_v_reg     <= b0_v_reg;

        b2_a_reg     <= BLEND_W'(b1_f00_reg) + BLEND_W'((pa + 64'sd32768) >>> 16);
        b2_b_reg     <= BLEND_W'(b1_f01_reg) + BLEND_W'((pb + 64'sd32768) >>> 16);
        b2_v_reg     <= b1_v_reg;

        b3_a_reg     <= b2_a_reg;
        b3_hh_reg    <= vh * eh;
        b3_hl_reg    <= vh * el;
        b3_lh_reg    <= vl * eh;
        b3_ll_reg    <= vl * el;

        b4_a_reg     <= b3_a_reg;
        b4_ps_reg    <= ps;

        if (r > OUT_HI)
        begin
            value_reg <= SAMPLE_W'(OUT_HI);
            sat_reg   <= 1'b1;
        end
        else if (r < OUT_LO)
        begin
            value_reg <= SAMPLE_W'(OUT_LO);
            sat_reg   <= 1'b1;
        end
        else
        begin
            value_reg <= r[SAMPLE_W-1:0];
            sat_reg   <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

[hdl/bilinear_image_resample.sv]
// ---------------------------------------------------------------------------
// bilinear_image_resample
// Bilinear resampler of a banked 256 x 256 source image with Q16.16 affine
// addressing. Load items fill the image; query items return one blended sample.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle while busy is low, loads and queries mixed in any order.
// A query's result strobe (done) is high for one cycle. A query passes the front
// end register, the queue and the four parity banks, which serve all neighbours
// together, then a five-stage multiplier pipeline blends them into the output.
// Reset clears control state and loads the default registers; the image store
// is not cleared. The receiver cannot stall, so busy stays low in normal use.
module bilinear_image_resample import bir_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cmd,
    input  logic [LOAD_W-1:0]    col,
    input  logic [LOAD_W-1:0]    row,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic [SAMPLE_W-1:0]  value,
    output logic                 saturated,
    output logic                 done
);

    cfg_t cfg_reg;
    logic accept;
    logic push;
    job_t job_in;
    job_t job_out;
    logic pop;
    logic empty;
    logic nearly_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin   <= '0;
            cfg_reg.x_step     <= 32'sd65536;
            cfg_reg.y_origin   <= '0;
            cfg_reg.y_step     <= 32'sd65536;
            cfg_reg.src_width  <= SIZE_W'(MAX_W);
            cfg_reg.src_height <= SIZE_W'(MAX_H);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_ORIGIN:   cfg_reg.x_origin   <= cfg_data;
                REG_X_STEP:     cfg_reg.x_step     <= cfg_data;
                REG_Y_ORIGIN:   cfg_reg.y_origin   <= cfg_data;
                REG_Y_STEP:     cfg_reg.y_step     <= cfg_data;
                REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data[SIZE_W-1:0];
                REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data[SIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign busy   = nearly_full;
    assign accept = start && !busy;

    bir_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .col    (col),
        .row    (row),
        .sample (sample),
        .cfg    (cfg_reg),
        .push   (push),
        .job    (job_in)
    );

    bir_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .job_in      (job_in),
        .pop         (pop),
        .job_out     (job_out),
        .empty       (empty),
        .nearly_full (nearly_full)
    );

    bir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .job       (job_out),
        .pop       (pop),
        .done      (done),
        .value     (value),
        .saturated (saturated)
    );

endmodule

[verif/bir_checker.sv]
// ---------------------------------------------------------------------------
// bir_checker
// Watches the item, register and result channels of the bilinear resampler,
// keeps its own copy of the image and registers, predicts each query's result
// and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module bir_checker import bir_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 cmd,
    input  logic [LOAD_W-1:0]    col,
    input  logic [LOAD_W-1:0]    row,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [SAMPLE_W-1:0]  value,
    input  logic                 saturated,
    input  logic                 done,
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                saturated;
    } pixel_t;

    localparam logic signed [127:0] PROD_MAX = 128'sd1 <<< 62;

    cfg_t                     regs;
    logic signed [SAMPLE_W-1:0] image [0:MAX_W*MAX_H-1];
    pixel_t                   expected_pixels[$];

    assign pending = expected_pixels.size();

    function automatic longint size_of(logic [SIZE_W-1:0] s, longint bound);
        longint r;
        r = s;
        if (r == 0)
            r = 1;
        else if (r > bound)
            r = bound;
        return r;
    endfunction

    // Coordinate of one axis: base index, neighbour and signed fraction.
    function automatic void locate(longint origin, longint step, longint t, longint sz,
                                   output longint i0, output longint i1,
                                   output longint frac);
        longint c;
        longint b;
        c = origin + t * step;
        b = (c >= 0) ? (c >>> 16) : -((-c) >>> 16);
        if (b < 0)
            b = 0;
        if (b > sz - 1)
            b = sz - 1;
        i0 = b;
        i1 = (b + 1 < sz) ? b + 1 : sz - 1;
        frac = c - b * 65536;
    endfunction

    // Scaled product limited to the multiplier range, then rounded half up.
    function automatic logic signed [127:0] scale(logic signed [127:0] f,
                                                 logic signed [127:0] d);
        logic signed [127:0] p;
        p = f * d;
        if (p > PROD_MAX)
            p = PROD_MAX;
        else if (p < -PROD_MAX)
            p = -PROD_MAX;
        return (p + 128'sd32768) >>> 16;
    endfunction

    function automatic pixel_t resample(logic [LOAD_W-1:0] tc, logic [LOAD_W-1:0] tr);
        longint x0, x1, y0, y1, u, v;
        logic signed [127:0] f00, f10, f01, f11, a, b, r;
        pixel_t px;
        locate(longint'(regs.x_origin), longint'(regs.x_step), longint'(tc),
               size_of(regs.src_width, MAX_W), x0, x1, u);
        locate(longint'(regs.y_origin), longint'(regs.y_step), longint'(tr),
               size_of(regs.src_height, MAX_H), y0, y1, v);
        f00 = image[y0 * MAX_W + x0];
        f10 = image[y0 * MAX_W + x1];
        f01 = image[y1 * MAX_W + x0];
        f11 = image[y1 * MAX_W + x1];
        a = f00 + scale(u, f10 - f00);
        b = f01 + scale(u, f11 - f01);
        r = a + scale(v, b - a);
        px.saturated = 1'b1;
        if (r > 128'sd32767)
            r = 128'sd32767;
        else if (r < -128'sd32768)
            r = -128'sd32768;
        else
            px.saturated = 1'b0;
        px.value = r[SAMPLE_W-1:0];
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.x_origin   <= '0;
            regs.x_step     <= 32'sd65536;
            regs.y_origin   <= '0;
            regs.y_step     <= 32'sd65536;
            regs.src_width  <= SIZE_W'(256);
            regs.src_height <= SIZE_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_ORIGIN:   regs.x_origin   <= cfg_data;
                REG_X_STEP:     regs.x_step     <= cfg_data;
                REG_Y_ORIGIN:   regs.y_origin   <= cfg_data;
                REG_Y_STEP:     regs.y_step     <= cfg_data;
                REG_SRC_WIDTH:  regs.src_width  <= cfg_data[SIZE_W-1:0];
                REG_SRC_HEIGHT: regs.src_height <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %h saturated %b",
                                 value, saturated);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.value !== value || want.saturated !== saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %h/%b, got %h/%b",
                                     want.value, want.saturated, value, saturated);
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd)
                    expected_pixels.push_back(resample(col, row));
                else if (col < MAX_W && row < MAX_H)
                    image[row * MAX_W + col] = sample;
            end
        end
    end

endmodule

[verif/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Drives load and query items into the bilinear resampler under several
// register settings, with random bursts and gaps, and reports the verdict.
// Queries only touch image entries that have been loaded beforehand.
// ---------------------------------------------------------------------------
module tb import bir_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int   STALL_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 cmd = CMD_LOAD;
    logic [LOAD_W-1:0]    col = '0;
    logic [LOAD_W-1:0]    row = '0;
    logic [SAMPLE_W-1:0]  sample = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_X_ORIGIN;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic [SAMPLE_W-1:0]  value;
    logic                 saturated;
    logic                 done;
    int                   mismatches;
    int                   pending;
    int                   quiet_cycles = 0;
    int                   burst_left = 0;

    always #1 clk = ~clk;

    bilinear_image_resample dut (.*);
    bir_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] any_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Holds one item on the ports until the block takes it, then maybe idles.
    task automatic send(logic c, logic [LOAD_W-1:0] x, logic [LOAD_W-1:0] y,
                        logic [SAMPLE_W-1:0] s);
        logic was_busy;
        start  <= 1'b1;
        cmd    <= c;
        col    <= x;
        row    <= y;
        sample <= s;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Registers change only once every expected result has arrived.
    task automatic write_regs(cfg_t c);
        logic [CFG_W-1:0] vals [6];
        vals = '{c.x_origin, c.x_step, c.y_origin, c.y_step,
                 CFG_W'(c.src_width), CFG_W'(c.src_height)};
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] any_coeff();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'h0001_0000;
            5:       return CFG_W'($urandom_range(0, 32'h0008_0000));
            default: return $urandom();
        endcase
    endfunction

    // With a zero step every query lands on the origin, which is kept near
    // the loaded corner patches of the full-size image.
    function automatic logic [CFG_W-1:0] corner_origin();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000 | CFG_W'($urandom());
            1:       return CFG_W'($urandom_range(0, 16'hffff));
            2:       return {16'd254, 16'($urandom())};
            3:       return {16'd255, 16'($urandom())};
            default: return {1'b0, 15'($urandom_range(256, 32767)), 16'($urandom())};
        endcase
    endfunction

    initial
    begin
        cfg_t c;
        int   w, h, n;
        logic [7:0] edges [4];
        edges = '{8'd0, 8'd1, 8'd254, 8'd255};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner patches under the reset registers, loads outside the store,
        // and queries that clamp at both edges of the full image.
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send(CMD_LOAD, LOAD_W'(edges[j]), LOAD_W'(edges[i]),
                     (i + j) % 2 ? 16'h7fff : 16'h8000);
        send(CMD_LOAD, 12'hfff, 12'hfff, 16'h1234);
        send(CMD_LOAD, 12'd300, 12'd0, 16'h5555);
        send(CMD_QUERY, 12'd0, 12'd0, 16'hffff);
        send(CMD_QUERY, 12'd254, 12'd254, 16'h0000);
        send(CMD_QUERY, 12'hfff, 12'hfff, 16'h0000);
        send(CMD_QUERY, 12'd255, 12'd0, 16'h0000);
        send(CMD_QUERY, 12'd0, 12'd255, 16'h0000);

        for (int phase = 0; phase < 16; phase++)
        begin
            if (phase % 4 == 3)
            begin
                c.x_origin   = corner_origin();
                c.y_origin   = corner_origin();
                c.x_step     = '0;
                c.y_step     = '0;
                c.src_width  = SIZE_W'($urandom_range(256, 511));
                c.src_height = SIZE_W'($urandom_range(256, 511));
                write_regs(c);
                for (int k = 0; k < 60; k++)
                    send($urandom_range(0, 5) != 0, LOAD_W'($urandom()),
                         LOAD_W'($urandom()), any_sample());
            end
            else
            begin
                c.x_origin   = any_coeff();
                c.x_step     = any_coeff();
                c.y_origin   = any_coeff();
                c.y_step     = any_coeff();
                c.src_width  = SIZE_W'($urandom_range(0, 8));
                c.src_height = SIZE_W'($urandom_range(0, 8));
                write_regs(c);
                w = (c.src_width == 0) ? 1 : c.src_width;
                h = (c.src_height == 0) ? 1 : c.src_height;
                for (int y = 0; y < h; y++)
                    for (int x = 0; x < w; x++)
                        send(CMD_LOAD, LOAD_W'(x), LOAD_W'(y), any_sample());
                n = 0;
                while (n < 50)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send(CMD_LOAD, LOAD_W'($urandom_range(0, w - 1)),
                             LOAD_W'($urandom_range(0, h - 1)), any_sample());
                    else
                    begin
                        send(CMD_QUERY, LOAD_W'($urandom()), LOAD_W'($urandom()),
                             SAMPLE_W'($urandom()));
                        n++;
                    end
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hdl/bir_pkg.sv
hdl/bir_ram.sv
hdl/bir_front.sv
hdl/bir_queue.sv
hdl/bir_back.sv
hdl/bilinear_image_resample.sv
verif/bir_checker.sv
verif/tb.sv
